FILE: rtl/core/sci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg
// Shared constants, codes and a helper for the spotlight cone influence block.
// ----------------------------------------------------------------------------
package sci_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEAR    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AIM     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND  = 3'd6;

  // Aim modes
  localparam logic [1:0] AIM_FORWARD = 2'd0;
  localparam logic [1:0] AIM_DOWN    = 2'd1;
  localparam logic [1:0] AIM_GROUND  = 2'd2;

  // Resolved light direction
  localparam logic [1:0] DIR_FWD  = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;

  localparam logic [31:0] NEAR_EPS   = 32'd7;
  localparam logic [63:0] DIR_EPS_SQ = 64'd4295;
  localparam logic signed [32:0] GROUND_EPS = 33'sd65;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Reset values of the cosine registers
  localparam logic [15:0] INNER_RESET = 16'd16384;
  localparam logic [15:0] OUTER_RESET = 16'd0;

  // Leading zero count of a 32-bit word, 32 for zero
  function automatic logic [5:0] lzc32(input logic [31:0] val);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!hit && val[i]) begin
        n   = 6'(31 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/spotlight_cone_influence.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spotlight_cone_influence
// Spotlight cone and distance attenuation of one world point per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a world point, the light position and the owner forward
//   vector (signed Q16.16). The item is taken on that edge; busy stays low, so
//   a new item may enter on every clock.
//   The influence (Q1.16, 65536 = full) comes out at the end of the pipeline,
//   marked by a one-cycle done pulse. The receiver cannot stall.
//   Items leave in the order they entered, one per cycle at most.
//   The pipeline is a chain of one-bit-per-stage units: a 32-stage square root,
//   a 31-stage normalize divider, a 31-stage cosine divider and a 16-stage
//   factor divider, plus eleven stages of setup, products and sums.
//   Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
//   is always high. Write registers only while no item is in flight.
//   Synchronous reset clears the pipeline valid bits and loads the register
//   reset values (light off, so every influence is zero until enabled).
// ----------------------------------------------------------------------------
module spotlight_cone_influence
  import sci_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  input  logic signed [31:0]     light_x,
  input  logic signed [31:0]     light_y,
  input  logic signed [31:0]     light_z,
  input  logic signed [31:0]     forward_x,
  input  logic signed [31:0]     forward_y,
  input  logic signed [31:0]     forward_z,
  output logic                   done,
  output logic [16:0]            influence,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Sideband through the square root: everything needed from normalize on
  typedef struct packed {
    logic        zero;
    logic [1:0]  dir;
    logic [30:0] vm0, vm1, vm2;
    logic [2:0]  vneg;
    logic [2:0]  fneg;
    logic [31:0] sm0, sm1, sm2;
  } side_a_t;

  // Sideband through the normalize divider
  typedef struct packed {
    logic        zero;
    logic [1:0]  dir;
    logic [30:0] vm0, vm1, vm2;
    logic [2:0]  vneg;
    logic [2:0]  fneg;
    logic [30:0] dlen;
  } side_b_t;

  // Sideband through the cosine divider
  typedef struct packed {
    logic        zero;
    logic        dneg;
    logic [30:0] dlen;
  } side_c_t;

  // Sideband through the angle factor divider
  typedef struct packed {
    logic zero;
    logic aclamp;
    logic dist_ok;
    logic dclamp;
  } side_d_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               light_enabled;
  logic [30:0]        reach_range;
  logic [30:0]        near_distance;
  logic signed [15:0] inner_cosine;
  logic signed [15:0] outer_cosine;
  logic [1:0]         aim_mode;
  logic signed [31:0] ground_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_enabled <= 1'b0;
      reach_range   <= '0;
      near_distance <= '0;
      inner_cosine  <= INNER_RESET;
      outer_cosine  <= OUTER_RESET;
      aim_mode      <= AIM_FORWARD;
      ground_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED: light_enabled <= cfg_data[0];
        REG_RANGE:   reach_range   <= cfg_data[30:0];
        REG_NEAR:    near_distance <= cfg_data[30:0];
        REG_INNER:   inner_cosine  <= cfg_data[15:0];
        REG_OUTER:   outer_cosine  <= cfg_data[15:0];
        REG_AIM:     aim_mode      <= cfg_data[1:0];
        REG_GROUND:  ground_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Values derived from configuration only; settle while the block is idle
  logic [30:0]        near_clamp;
  logic [63:0]        lim_sq;
  logic [61:0]        range_sq;
  logic [30:0]        dist_den;
  logic               range_gt_near;
  logic               cfg_zero;
  logic               angle_full;
  logic [15:0]        span;
  logic signed [31:0] outer30;
  logic [31:0]        lim;

  always_comb begin
    lim = {1'b0, near_clamp} + NEAR_EPS;
  end

  always_ff @(posedge clk) begin
    near_clamp    <= (near_distance < reach_range) ? near_distance : reach_range;
    lim_sq        <= lim * lim;
    range_sq      <= reach_range * reach_range;
    dist_den      <= reach_range - near_clamp;
    range_gt_near <= reach_range > near_clamp;
    cfg_zero      <= !light_enabled || (reach_range == '0);
    angle_full    <= inner_cosine <= outer_cosine;
    span          <= 16'(inner_cosine - outer_cosine);
    outer30       <= {outer_cosine, 16'b0};
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: differences and aim decode
  // --------------------------------------------------------------------------
  logic signed [31:0] pt [3];
  logic signed [31:0] lt [3];
  logic signed [31:0] fw [3];
  logic signed [32:0] dy;

  always_comb begin
    pt[0] = point_x;   pt[1] = point_y;   pt[2] = point_z;
    lt[0] = light_x;   lt[1] = light_y;   lt[2] = light_z;
    fw[0] = forward_x; fw[1] = forward_y; fw[2] = forward_z;
    dy    = 33'(ground_height) - 33'(light_y);
  end

  logic               s1_vld;
  logic signed [32:0] s1_v [3];
  logic signed [31:0] s1_f [3];
  logic [1:0]         s1_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      s1_v[i] <= 33'(pt[i]) - 33'(lt[i]);
      s1_f[i] <= fw[i];
    end
    case (aim_mode)
      AIM_FORWARD: s1_dir <= DIR_FWD;
      AIM_GROUND: begin
        if (dy > GROUND_EPS) begin
          s1_dir <= DIR_UP;
        end else begin
          s1_dir <= DIR_DOWN;
        end
      end
      default: s1_dir <= DIR_DOWN;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes and the per-axis range check
  // --------------------------------------------------------------------------
  logic [32:0] vabs [3];
  logic [32:0] fabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vabs[i] = s1_v[i][32] ? 33'(-s1_v[i]) : s1_v[i];
      fabs[i] = s1_f[i][31] ? 33'(-33'(s1_f[i])) : 33'(s1_f[i]);
    end
  end

  logic        s2_vld;
  logic [31:0] s2_vm [3];
  logic [31:0] s2_fm [3];
  logic [2:0]  s2_vneg;
  logic [2:0]  s2_fneg;
  logic        s2_vbig;
  logic [1:0]  s2_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s2_vm[i]   <= vabs[i][31:0];
      s2_fm[i]   <= fabs[i][31:0];
      s2_vneg[i] <= s1_v[i][32];
      s2_fneg[i] <= s1_f[i][31];
    end
    s2_vbig <= (vabs[0][31:0] > {1'b0, reach_range}) || (vabs[1][31:0] > {1'b0, reach_range})
            || (vabs[2][31:0] > {1'b0, reach_range});
    s2_dir  <= s1_dir;
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares and the forward scale shift
  // --------------------------------------------------------------------------
  logic [31:0] fmax;
  logic [5:0]  fmax_lz;

  always_comb begin
    fmax = s2_fm[0];
    if (s2_fm[1] > fmax) begin
      fmax = s2_fm[1];
    end
    if (s2_fm[2] > fmax) begin
      fmax = s2_fm[2];
    end
    fmax_lz = lzc32(fmax);
  end

  logic        s3_vld;
  logic [63:0] s3_vsq [3];
  logic [63:0] s3_fsq [3];
  logic [30:0] s3_vm  [3];
  logic [31:0] s3_fm  [3];
  logic [2:0]  s3_vneg;
  logic [2:0]  s3_fneg;
  logic        s3_vbig;
  logic [1:0]  s3_dir;
  logic [4:0]  s3_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s3_vsq[i] <= s2_vm[i] * s2_vm[i];
      s3_fsq[i] <= s2_fm[i] * s2_fm[i];
      s3_vm[i]  <= s2_vm[i][30:0];
      s3_fm[i]  <= s2_fm[i];
    end
    s3_vneg  <= s2_vneg;
    s3_fneg  <= s2_fneg;
    s3_vbig  <= s2_vbig;
    s3_dir   <= s2_dir;
    s3_shift <= (fmax_lz == 6'd0) ? 5'd0 : 5'(fmax_lz - 6'd1);
  end

  // --------------------------------------------------------------------------
  // Stage 4: sums of squares, scaled forward components
  // --------------------------------------------------------------------------
  logic        s4_vld;
  logic [63:0] s4_dist2;
  logic [63:0] s4_f2;
  logic [31:0] s4_sm [3];
  logic [30:0] s4_vm [3];
  logic [2:0]  s4_vneg;
  logic [2:0]  s4_fneg;
  logic        s4_vbig;
  logic [1:0]  s4_dir;
  logic [4:0]  s4_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_dist2 <= s3_vsq[0] + s3_vsq[1] + s3_vsq[2];
    s4_f2    <= s3_fsq[0] + s3_fsq[1] + s3_fsq[2];
    for (int i = 0; i < 3; i++) begin
      s4_sm[i] <= 32'(s3_fm[i] << s3_shift);
      s4_vm[i] <= s3_vm[i];
    end
    s4_vneg  <= s3_vneg;
    s4_fneg  <= s3_fneg;
    s4_vbig  <= s3_vbig;
    s4_dir   <= s3_dir;
    s4_shift <= s3_shift;
  end

  // --------------------------------------------------------------------------
  // Stage 5: near / far tests, direction fallback, scaled length squared
  // --------------------------------------------------------------------------
  logic        s5_vld;
  logic [63:0] s5_dist2;
  logic [63:0] s5_lensq;
  side_a_t     s5_side;
  logic        use_fwd;

  always_comb begin
    use_fwd = (s4_dir == DIR_FWD) && (s4_f2 >= DIR_EPS_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_dist2      <= s4_dist2;
    s5_lensq      <= s4_f2 << {s4_shift, 1'b0};
    s5_side.zero  <= cfg_zero || s4_vbig || (s4_dist2 <= lim_sq)
                  || (s4_dist2 > {2'b0, range_sq});
    if (use_fwd) begin
      s5_side.dir <= DIR_FWD;
    end else if (s4_dir == DIR_UP) begin
      s5_side.dir <= DIR_UP;
    end else begin
      s5_side.dir <= DIR_DOWN;
    end
    s5_side.vm0  <= s4_vm[0];
    s5_side.vm1  <= s4_vm[1];
    s5_side.vm2  <= s4_vm[2];
    s5_side.vneg <= s4_vneg;
    s5_side.fneg <= s4_fneg;
    s5_side.sm0  <= s4_sm[0];
    s5_side.sm1  <= s4_sm[1];
    s5_side.sm2  <= s4_sm[2];
  end

  // --------------------------------------------------------------------------
  // Square roots: distance and forward length, side by side
  // --------------------------------------------------------------------------
  logic        rt_vld;
  logic [31:0] rt_dist;
  logic [31:0] rt_len;
  side_a_t     rt_side;
  logic [$bits(side_a_t)-1:0] rt_side_bits;

  sci_isqrt #(.XW(64), .SW($bits(side_a_t))) u_sqrt_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .in_x      (s5_dist2),
    .in_side   (s5_side),
    .out_valid (rt_vld),
    .out_root  (rt_dist),
    .out_side  (rt_side_bits)
  );

  sci_isqrt #(.XW(64), .SW(1)) u_sqrt_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .in_x      (s5_lensq),
    .in_side   (1'b0),
    .out_valid (),
    .out_root  (rt_len),
    .out_side  ()
  );

  assign rt_side = side_a_t'(rt_side_bits);

  // --------------------------------------------------------------------------
  // Normalize: each scaled forward component times 2^30 over its length
  // --------------------------------------------------------------------------
  side_b_t     nb_side_in;
  logic        nd_vld;
  logic [30:0] nd_q [3];
  logic [$bits(side_b_t)-1:0] nd_side_bits;
  side_b_t     nd_side;

  always_comb begin
    nb_side_in.zero = rt_side.zero;
    nb_side_in.dir  = rt_side.dir;
    nb_side_in.vm0  = rt_side.vm0;
    nb_side_in.vm1  = rt_side.vm1;
    nb_side_in.vm2  = rt_side.vm2;
    nb_side_in.vneg = rt_side.vneg;
    nb_side_in.fneg = rt_side.fneg;
    nb_side_in.dlen = rt_dist[30:0];
  end

  sci_udiv #(.NW(62), .DW(32), .QW(31), .SW($bits(side_b_t))) u_norm_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_num    ({rt_side.sm0, 30'b0}),
    .in_den    (rt_len),
    .in_side   (nb_side_in),
    .out_valid (nd_vld),
    .out_quo   (nd_q[0]),
    .out_side  (nd_side_bits)
  );

  sci_udiv #(.NW(62), .DW(32), .QW(31), .SW(1)) u_norm_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_num    ({rt_side.sm1, 30'b0}),
    .in_den    (rt_len),
    .in_side   (1'b0),
    .out_valid (),
    .out_quo   (nd_q[1]),
    .out_side  ()
  );

  sci_udiv #(.NW(62), .DW(32), .QW(31), .SW(1)) u_norm_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_vld),
    .in_num    ({rt_side.sm2, 30'b0}),
    .in_den    (rt_len),
    .in_side   (1'b0),
    .out_valid (),
    .out_quo   (nd_q[2]),
    .out_side  ()
  );

  assign nd_side = side_b_t'(nd_side_bits);

  // --------------------------------------------------------------------------
  // Stage 6: signed direction and offset vectors
  // --------------------------------------------------------------------------
  logic [30:0] nd_vm [3];

  always_comb begin
    nd_vm[0] = nd_side.vm0;
    nd_vm[1] = nd_side.vm1;
    nd_vm[2] = nd_side.vm2;
  end

  logic               s6_vld;
  logic signed [31:0] s6_v [3];
  logic signed [31:0] s6_d [3];
  logic               s6_zero;
  logic [30:0]        s6_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= nd_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s6_v[i] <= nd_side.vneg[i] ? -$signed({1'b0, nd_vm[i]}) : $signed({1'b0, nd_vm[i]});
      if (nd_side.dir == DIR_FWD) begin
        s6_d[i] <= nd_side.fneg[i] ? -$signed({1'b0, nd_q[i]}) : $signed({1'b0, nd_q[i]});
      end else if (i == 1) begin
        s6_d[i] <= (nd_side.dir == DIR_UP) ? ONE_Q30 : -ONE_Q30;
      end else begin
        s6_d[i] <= '0;
      end
    end
    s6_zero <= nd_side.zero;
    s6_dist <= nd_side.dlen;
  end

  // --------------------------------------------------------------------------
  // Stage 7: component products; stage 8: dot sum; stage 9: magnitude
  // --------------------------------------------------------------------------
  logic               s7_vld;
  logic signed [63:0] s7_p [3];
  logic               s7_zero;
  logic [30:0]        s7_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s7_p[i] <= 64'(s6_v[i]) * 64'(s6_d[i]);
    end
    s7_zero <= s6_zero;
    s7_dist <= s6_dist;
  end

  logic               s8_vld;
  logic signed [63:0] s8_dot;
  logic               s8_zero;
  logic [30:0]        s8_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= s7_vld;
    end
    s8_dot  <= s7_p[0] + s7_p[1] + s7_p[2];
    s8_zero <= s7_zero;
    s8_dist <= s7_dist;
  end

  logic        s9_vld;
  logic [62:0] s9_dmag;
  side_c_t     s9_side;
  logic [63:0] dot_abs;

  always_comb begin
    dot_abs = s8_dot[63] ? 64'(-s8_dot) : 64'(s8_dot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else begin
      s9_vld <= s8_vld;
    end
    s9_dmag      <= dot_abs[62:0];
    s9_side.zero <= s8_zero;
    s9_side.dneg <= s8_dot[63];
    s9_side.dlen <= s8_dist;
  end

  // --------------------------------------------------------------------------
  // Cosine: dot over distance, truncated toward zero
  // --------------------------------------------------------------------------
  logic        cd_vld;
  logic [30:0] cd_q;
  logic [$bits(side_c_t)-1:0] cd_side_bits;
  side_c_t     cd_side;

  sci_udiv #(.NW(63), .DW(31), .QW(31), .SW($bits(side_c_t))) u_cos_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_vld),
    .in_num    (s9_dmag),
    .in_den    (s9_side.dlen),
    .in_side   (s9_side),
    .out_valid (cd_vld),
    .out_quo   (cd_q),
    .out_side  (cd_side_bits)
  );

  assign cd_side = side_c_t'(cd_side_bits);

  // --------------------------------------------------------------------------
  // Stage 10: cone test and factor setup
  // --------------------------------------------------------------------------
  logic signed [32:0] cos30;
  logic signed [32:0] adiff;
  logic [31:0]        dnum;

  always_comb begin
    cos30 = cd_side.dneg ? -$signed({2'b0, cd_q}) : $signed({2'b0, cd_q});
    adiff = cos30 - 33'(outer30);
    dnum  = {1'b0, reach_range} - {1'b0, cd_side.dlen};
  end

  logic        s10_vld;
  logic [31:0] s10_adiff;
  logic [15:0] s10_span;
  logic [30:0] s10_dnum;
  logic [30:0] s10_dden;
  side_d_t     s10_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else begin
      s10_vld <= cd_vld;
    end
    s10_adiff        <= adiff[31:0];
    s10_span         <= span;
    s10_dnum         <= dnum[30:0];
    s10_dden         <= dist_den;
    s10_side.zero    <= cd_side.zero || (cos30 < 33'(outer30));
    s10_side.aclamp  <= angle_full || (adiff[31:0] >= {span, 16'b0});
    s10_side.dist_ok <= range_gt_near && (reach_range >= cd_side.dlen);
    s10_side.dclamp  <= dnum[30:0] >= dist_den;
  end

  // --------------------------------------------------------------------------
  // Angle and distance factor dividers, side by side
  // --------------------------------------------------------------------------
  logic        fd_vld;
  logic [15:0] fd_a;
  logic [15:0] fd_d;
  logic [$bits(side_d_t)-1:0] fd_side_bits;
  side_d_t     fd_side;

  sci_udiv #(.NW(32), .DW(16), .QW(16), .SW($bits(side_d_t))) u_angle_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s10_vld),
    .in_num    (s10_adiff),
    .in_den    (s10_span),
    .in_side   (s10_side),
    .out_valid (fd_vld),
    .out_quo   (fd_a),
    .out_side  (fd_side_bits)
  );

  sci_udiv #(.NW(47), .DW(31), .QW(16), .SW(1)) u_dist_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s10_vld),
    .in_num    ({s10_dnum, 16'b0}),
    .in_den    (s10_dden),
    .in_side   (1'b0),
    .out_valid (),
    .out_quo   (fd_d),
    .out_side  ()
  );

  assign fd_side = side_d_t'(fd_side_bits);

  // --------------------------------------------------------------------------
  // Stage 11: clamp, product of the two factors, output register
  // --------------------------------------------------------------------------
  logic [16:0] a16;
  logic [16:0] d16;
  logic [33:0] prod;

  always_comb begin
    a16 = fd_side.aclamp ? ONE_Q16 : {1'b0, fd_a};
    if (!fd_side.dist_ok) begin
      d16 = '0;
    end else if (fd_side.dclamp) begin
      d16 = ONE_Q16;
    end else begin
      d16 = {1'b0, fd_d};
    end
    prod = a16 * d16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fd_vld;
    end
    influence <= fd_side.zero ? '0 : prod[32:16];
  end

endmodule

FILE: rtl/core/sci_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module sci_isqrt #(
  parameter int XW = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [XW-1:0] in_x,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [XW/2-1:0] out_root,
  output logic [SW-1:0] out_side
);

  localparam int RW = XW / 2;

  logic [RW-1:0] vld;
  logic [XW-1:0] xr    [RW];
  logic [XW-1:0] rr    [RW];
  logic [SW-1:0] sr    [RW];
  logic [XW-1:0] src_x [RW];
  logic [XW-1:0] src_r [RW];
  logic [XW:0]   trial [RW];
  logic [XW-1:0] nx    [RW];
  logic [XW-1:0] nr    [RW];

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      src_x[i] = (i == 0) ? in_x : xr[(i == 0) ? 0 : i - 1];
      src_r[i] = (i == 0) ? '0 : rr[(i == 0) ? 0 : i - 1];
      trial[i] = {1'b0, src_r[i]} + ((XW+1)'(1) << (2 * (RW - 1 - i)));
      if ({1'b0, src_x[i]} >= trial[i]) begin
        nx[i] = XW'({1'b0, src_x[i]} - trial[i]);
        nr[i] = XW'({2'b0, src_r[i][XW-1:1]} + ((XW+1)'(1) << (2 * (RW - 1 - i))));
      end else begin
        nx[i] = src_x[i];
        nr[i] = {1'b0, src_r[i][XW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[RW-2:0], in_valid};
    end
    for (int i = 0; i < RW; i++) begin
      xr[i] <= nx[i];
      rr[i] <= nr[i];
      sr[i] <= (i == 0) ? in_side : sr[(i == 0) ? 0 : i - 1];
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = rr[RW-1][RW-1:0];
  assign out_side  = sr[RW-1];

endmodule

FILE: rtl/core/sci_udiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_udiv
// Pipelined restoring divider, one quotient bit per stage, floor quotient.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module sci_udiv #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0] vld;
  logic [NW-1:0] rem     [QW];
  logic [DW-1:0] den     [QW];
  logic [QW-1:0] quo     [QW];
  logic [SW-1:0] side    [QW];
  logic [NW-1:0] src_rem [QW];
  logic [DW-1:0] src_den [QW];
  logic [QW-1:0] src_quo [QW];
  logic [CW-1:0] shifted [QW];
  logic [NW-1:0] nrem    [QW];
  logic [QW-1:0] nquo    [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      src_rem[i] = (i == 0) ? in_num : rem[(i == 0) ? 0 : i - 1];
      src_den[i] = (i == 0) ? in_den : den[(i == 0) ? 0 : i - 1];
      src_quo[i] = (i == 0) ? '0 : quo[(i == 0) ? 0 : i - 1];
      shifted[i] = CW'(src_den[i]) << (QW - 1 - i);
      if (CW'(src_rem[i]) >= shifted[i]) begin
        nrem[i] = NW'(CW'(src_rem[i]) - shifted[i]);
        nquo[i] = src_quo[i] | (QW'(1) << (QW - 1 - i));
      end else begin
        nrem[i] = src_rem[i];
        nquo[i] = src_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-2:0], in_valid};
    end
    for (int i = 0; i < QW; i++) begin
      rem[i]  <= nrem[i];
      den[i]  <= src_den[i];
      quo[i]  <= nquo[i];
      side[i] <= (i == 0) ? in_side : side[(i == 0) ? 0 : i - 1];
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

FILE: verif/sci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_checker
// Watches the item, result and register channels of the spotlight cone block,
// computes the expected influence of every accepted item and compares it with
// what comes out, in order.
// ----------------------------------------------------------------------------
module sci_checker
  import sci_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  input  logic signed [31:0]     light_x,
  input  logic signed [31:0]     light_y,
  input  logic signed [31:0]     light_z,
  input  logic signed [31:0]     forward_x,
  input  logic signed [31:0]     forward_y,
  input  logic signed [31:0]     forward_z,
  input  logic                   done,
  input  logic [16:0]            influence,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  logic             lit;
  logic [30:0]      far_dist;
  logic [30:0]      cut_dist;
  logic signed [15:0] cos_in;
  logic signed [15:0] cos_out;
  logic [1:0]       aim;
  logic signed [31:0] ground_y;

  logic [16:0] influence_q[$];

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] absv(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [16:0] lit_amount(
      input logic signed [31:0] px, py, pz, lx, ly, lz, fx, fy, fz);
    longint v[3], dir[3], f[3], s[3];
    logic [63:0] rng, nr, d2, dlen, lim, a16, d16, f2, m, sum, len;
    longint dot, c30, in30, out30, scl, dy;
    rng = far_dist;
    nr  = cut_dist < far_dist ? cut_dist : far_dist;
    if (!lit || rng == 0) return 0;
    v[0] = longint'(px) - longint'(lx);
    v[1] = longint'(py) - longint'(ly);
    v[2] = longint'(pz) - longint'(lz);
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (absv(v[i]) > rng) return 0;
      d2 += absv(v[i]) * absv(v[i]);
    end
    lim = nr + 7;
    if (d2 <= lim * lim) return 0;
    if (d2 > rng * rng) return 0;
    dlen = root64(d2);
    dir[0] = 0; dir[1] = -(64'sd1 << 30); dir[2] = 0;
    if (aim == AIM_FORWARD) begin
      f[0] = fx; f[1] = fy; f[2] = fz;
      f2 = 0;
      for (int i = 0; i < 3; i++) f2 += absv(f[i]) * absv(f[i]);
      if (f2 >= 64'd4295) begin
        m = absv(f[0]);
        if (absv(f[1]) > m) m = absv(f[1]);
        if (absv(f[2]) > m) m = absv(f[2]);
        scl = 1;
        while (m < (64'd1 << 30)) begin
          m = m << 1;
          scl = scl * 2;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          s[i] = f[i] * scl;
          sum += absv(s[i]) * absv(s[i]);
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) dir[i] = (s[i] * (64'sd1 << 30)) / longint'(len);
      end
    end else if (aim == AIM_GROUND) begin
      dy = longint'(ground_y) - longint'(ly);
      if (dy > 65) dir[1] = 64'sd1 << 30;
      else if (dy < -65) dir[1] = -(64'sd1 << 30);
    end
    dot = 0;
    for (int i = 0; i < 3; i++) dot += v[i] * dir[i];
    c30   = dot / longint'(dlen);
    in30  = longint'(cos_in) * 65536;
    out30 = longint'(cos_out) * 65536;
    if (c30 < out30) return 0;
    if (in30 > out30) begin
      a16 = (64'(c30 - out30) * 65536) / 64'(in30 - out30);
      if (a16 > 65536) a16 = 65536;
    end else begin
      a16 = 65536;
    end
    if (rng > nr && rng >= dlen) begin
      d16 = ((rng - dlen) * 65536) / (rng - nr);
      if (d16 > 65536) d16 = 65536;
    end else begin
      d16 = 0;
    end
    return 17'((a16 * d16) >> 16);
  endfunction

  always @(posedge clk) begin
    logic [16:0] want;
    if (rst) begin
      lit <= 1'b0;
      far_dist <= '0;
      cut_dist <= '0;
      cos_in <= INNER_RESET;
      cos_out <= OUTER_RESET;
      aim <= AIM_FORWARD;
      ground_y <= '0;
      fail_count <= 0;
      pending <= 0;
      influence_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED: lit <= cfg_data[0];
          REG_RANGE: far_dist <= cfg_data[30:0];
          REG_NEAR: cut_dist <= cfg_data[30:0];
          REG_INNER: cos_in <= cfg_data[15:0];
          REG_OUTER: cos_out <= cfg_data[15:0];
          REG_AIM: aim <= cfg_data[1:0];
          REG_GROUND: ground_y <= cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (influence_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected influence %0d", influence);
        end else begin
          want = influence_q.pop_front();
          if (want !== influence) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("influence mismatch: expected %0d got %0d", want, influence);
          end
        end
      end
      if (start && !busy)
        influence_q.push_back(lit_amount(point_x, point_y, point_z, light_x, light_y,
                                         light_z, forward_x, forward_y, forward_z));
      pending <= influence_q.size();
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives world points through the spotlight cone block under several register
// settings, with random gaps; the checker predicts and compares each influence.
// ----------------------------------------------------------------------------
module testbench;
  import sci_pkg::*;

  // Pipeline depth of the block plus margin
  localparam int DRAIN_CYCLES = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [31:0] light_x = '0, light_y = '0, light_z = '0;
  logic signed [31:0] forward_x = '0, forward_y = '0, forward_z = '0;
  logic done;
  logic [16:0] influence;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count;
  int pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  spotlight_cone_influence u_dut (.*);
  sci_checker u_chk (.*);

  // Write one register; hold valid until the handshake lands
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setup(input logic en, input logic [31:0] rng, nr,
                            input logic [15:0] ci, co, input logic [1:0] am,
                            input logic [31:0] gy);
    write_reg(REG_ENABLED, {31'd0, en});
    write_reg(REG_RANGE, rng);
    write_reg(REG_NEAR, nr);
    write_reg(REG_INNER, ci);
    write_reg(REG_OUTER, co);
    write_reg(REG_AIM, {30'd0, am});
    write_reg(REG_GROUND, gy);
  endtask

  // Drop start, wait for every expected result, then let the pipeline drain
  task automatic go_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Present one item; wait for acceptance, then, if gaps is set, drop start for a random gap
  task automatic send_point(input logic [31:0] px, py, pz, lx, ly, lz, fx, fy, fz,
                            input bit gaps);
    int gap;
    start <= 1'b1;
    point_x <= px; point_y <= py; point_z <= pz;
    light_x <= lx; light_y <= ly; light_z <= lz;
    forward_x <= fx; forward_y <= fy; forward_z <= fz;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random vector component between -span and span
  function automatic logic [31:0] near_val(input int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random item around the light; mostly inside the range, some anywhere
  task automatic random_point(input logic [31:0] rng, input bit gaps);
    logic [31:0] lx, ly, lz, fx, fy, fz;
    int span;
    lx = $urandom; ly = $urandom; lz = $urandom;
    lx = {lx[31], lx[31], lx[29:0]} >>> 1;
    ly = {ly[31], ly[31], ly[29:0]} >>> 1;
    lz = {lz[31], lz[31], lz[29:0]} >>> 1;
    fx = $urandom >>> $urandom_range(0, 31);
    fy = $urandom >>> $urandom_range(0, 31);
    fz = $urandom >>> $urandom_range(0, 31);
    if ($urandom_range(0, 9) == 0) begin
      fx = $urandom_range(0, 60) - 30; fy = $urandom_range(0, 60) - 30; fz = 0;
    end
    span = (rng > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : rng;
    if (span < 16) span = 16;
    if ($urandom_range(0, 7) == 0)
      send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 fx, fy, fz, gaps);
    else
      send_point(lx + near_val(span), ly + near_val(span), lz + near_val(span),
                 lx, ly, lz, fx, fy, fz, gaps);
  endtask

  initial begin
    logic [31:0] rng;
    int phase_items;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset state: light off, every influence zero
    send_point(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0);
    go_idle();

    // Directed: aim forward along +z, cone 0..1
    load_setup(1'b1, 32'h000A_0000, 32'h0001_0000, 16'sd16384, 16'sd0, AIM_FORWARD, 0);
    send_point(0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // on axis
    send_point(0, 0, 32'h0000_8000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // inside near
    send_point(0, 0, 32'h000B_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // beyond range
    send_point(32'h0007_0000, 0, 32'h0007_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // corner
    send_point(0, 0, 32'hFFFB_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // behind, outside cone
    send_point(32'h0003_0000, 0, 32'h0003_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0); // 45 deg
    send_point(0, 32'hFFFC_0000, 0, 0, 0, 0, 0, 0, 0, 0); // zero forward aims down
    send_point(0, 32'hFFFC_0000, 0, 0, 0, 0, 32'd20, 32'd20, 0, 0); // tiny forward
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    go_idle();

    // Directed: equal cosines, range equal to near, ground aim
    load_setup(1'b1, 32'h0004_0000, 32'h7FFF_FFFF, 16'sd8192, 16'sd8192, AIM_GROUND,
               32'h0000_0041);
    send_point(0, 32'hFFFE_0000, 0, 0, 0, 0, 0, 0, 0, 0); // ground at light height
    go_idle();
    load_setup(1'b1, 32'h0004_0000, 0, -16'sd16384, -16'sd16384, AIM_GROUND,
               32'h0010_0000);
    send_point(0, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 0, 0); // ground above: aim up
    send_point(0, 32'h0002_0000, 0, 0, 32'h000F_FFBE, 0, 0, 0, 0, 0);
    go_idle();
    write_reg(REG_AIM, 32'd3); // unused mode aims down
    send_point(0, 32'hFFFE_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    go_idle();
    load_setup(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16'sd16384, 16'sd16384, AIM_DOWN,
               32'h8000_0000);
    send_point(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    send_point(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    go_idle();

    // Random phases across several settings
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: rng = $urandom_range(16, 32'h0080_0000);
        1: rng = $urandom & 32'h7FFF_FFFF;
        2: rng = $urandom_range(1, 400);
        default: rng = 32'h7FFF_FFFF;
      endcase
      load_setup(ph != 5, rng, (ph == 7) ? 32'h7FFF_FFFF : (rng >> $urandom_range(1, 8)),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 16'($signed($urandom_range(0, 32768)) - 16384),
                 2'($urandom_range(0, 3)),
                 (ph == 2) ? 32'h7FFF_FFFF : $urandom);
      phase_items = 50;
      for (int n = 0; n < phase_items; n++)
        random_point(rng, (ph % 3) != 0 && (n % 25) < 18);
      go_idle();
    end
    go_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: spotlight_cone_influence.f
rtl/core/sci_pkg.sv
rtl/core/sci_isqrt.sv
rtl/core/sci_udiv.sv
rtl/core/spotlight_cone_influence.sv
verif/sci_checker.sv
verif/testbench.sv
